// ===== hw/rtl/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasteriser.
package mcr_pkg;

  localparam int PIX_BITS = 15;
  localparam int IDX_BITS = 3;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [IDX_BITS-1:0] IDX_LAST = 3'd7;

  typedef struct packed {
    logic                load_start;
    logic                sq_x;
    logic                sq_y;
    logic                root_step;
    logic                commit;
    logic                emit_pixel;
    logic                emit_done;
    logic                step_update;
    logic [IDX_BITS-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic finished;
    logic root_last;
  } status_t;

endpackage

// ===== hw/rtl/mcr_ctrl.sv =====
// Sequencing state machine and output valid for the circle rasteriser.
module mcr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             opcode,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  mcr_pkg::status_t status,
  output mcr_pkg::cmd_t    cmd
);
  import mcr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQX  = 3'd1;
  localparam logic [2:0] S_SQY  = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state, state_next;
  logic [IDX_BITS-1:0] idx, idx_next;
  logic                slot_free;
  logic                in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (opcode == OP_START) begin
            cmd.load_start = 1'b1;
            state_next     = S_SQX;
          end else if (status.active && !status.finished) begin
            idx_next   = '0;
            state_next = S_EMIT;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SQX: begin
        cmd.sq_x   = 1'b1;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.sq_y   = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_pixel = 1'b1;
          if (idx == IDX_LAST) begin
            cmd.step_update = 1'b1;
            state_next      = S_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.emit_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.emit_pixel || cmd.emit_done) out_valid <= 1'b1;
      else if (!out_stall)                 out_valid <= 1'b0;
    end
  end

  a_start_seq: assert property (@(posedge clk) disable iff (rst)
    in_accept && opcode == OP_START |=> state == S_SQX)
    else $error("start beat did not enter the squaring sequence");

  a_root_end: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT && status.root_last |=> state == S_FIN)
    else $error("root recurrence did not finish");

  a_emit_active: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> status.active && !status.finished)
    else $error("pixel emission without a circle in progress");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.step_update |=> state == S_IDLE && out_valid)
    else $error("last pixel of a step not followed by idle");

endmodule

// ===== hw/rtl/mcr_datapath.sv =====
// Circle state, radius root recurrence, decision update and output register.
module mcr_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mcr_pkg::cmd_t                      cmd,
  output mcr_pkg::status_t                   status,
  input  logic [COORD_BITS-1:0]              center_x,
  input  logic [COORD_BITS-1:0]              center_y,
  input  logic [COORD_BITS-1:0]              edge_x,
  input  logic [COORD_BITS-1:0]              edge_y,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
  output logic [mcr_pkg::IDX_BITS-1:0]       octant_index,
  output logic                               last_of_step,
  output logic                               done_res
);
  import mcr_pkg::*;

  localparam int SB  = COORD_BITS + 1;
  localparam int DB  = COORD_BITS + 5;
  localparam int NW  = 2 * COORD_BITS + 1;
  localparam int WW  = (SB > PIX_BITS) ? SB : PIX_BITS;
  localparam int CNT = $clog2(SB);

  logic [COORD_BITS-1:0] cx, cy;
  logic [SB-1:0]         x, y;
  logic [DB-1:0]         p;
  logic                  active;

  logic [COORD_BITS-1:0] mag_x, mag_y;
  logic [NW-1:0]         sq, op, res, one;
  logic [CNT-1:0]        cnt;

  // full-width squares of the magnitudes
  logic [2*COORD_BITS-1:0] sq_xx, sq_yy;
  assign sq_xx = mag_x * mag_x;
  assign sq_yy = mag_y * mag_y;

  // centre-to-edge differences, with a sign bit
  logic [COORD_BITS:0] dx, dy;
  assign dx = {1'b0, edge_x} - {1'b0, center_x};
  assign dy = {1'b0, edge_y} - {1'b0, center_y};

  logic [NW-1:0] trial;
  assign trial = res + one;

  assign status.active    = active;
  assign status.finished  = (x > y);
  assign status.root_last = (cnt == CNT'(SB - 1));

  // decision update
  logic [DB-1:0] xe, ye, dxy, p_next;
  assign xe  = DB'(x);
  assign ye  = DB'(y);
  assign dxy = xe - ye;
  assign p_next = p[DB-1] ? (p + (xe << 2) + DB'(6))
                          : (p + (dxy << 2) + DB'(10));

  // mirrored pixel select
  logic          use_swap, neg_x, neg_y;
  logic [WW-1:0] ax, ay, cxe, cye, sx, sy;
  always_comb begin
    use_swap = (cmd.idx == 3'd1) || (cmd.idx == 3'd2) ||
               (cmd.idx == 3'd5) || (cmd.idx == 3'd6);
    neg_x    = cmd.idx[2];
    neg_y    = (cmd.idx == 3'd2) || (cmd.idx == 3'd3) ||
               (cmd.idx == 3'd4) || (cmd.idx == 3'd5);
    ax  = use_swap ? WW'(y) : WW'(x);
    ay  = use_swap ? WW'(x) : WW'(y);
    cxe = WW'(cx);
    cye = WW'(cy);
    sx  = neg_x ? (cxe - ax) : (cxe + ax);
    sy  = neg_y ? (cye - ay) : (cye + ay);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.commit) begin
      active <= 1'b1;
    end else if (cmd.emit_done) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_start) begin
      cx    <= center_x;
      cy    <= center_y;
      mag_x <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      mag_y <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    end
    if (cmd.sq_x) sq <= NW'(sq_xx);
    if (cmd.sq_y) begin
      op  <= sq + NW'(sq_yy);
      res <= '0;
      one <= NW'(1) << (NW - 1);
      cnt <= '0;
    end
    // one root bit per cycle
    if (cmd.root_step) begin
      if (op >= trial) begin
        op  <= op - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
      cnt <= cnt + 1'b1;
    end
    if (cmd.commit) begin
      x <= '0;
      y <= res[SB-1:0];
      p <= DB'(3) - (DB'(res[SB-1:0]) << 1);
    end
    if (cmd.step_update) begin
      p <= p_next;
      x <= x + 1'b1;
      if (!p[DB-1] && y != '0) y <= y - 1'b1;
    end
    if (cmd.emit_pixel) begin
      pixel_x      <= sx[PIX_BITS-1:0];
      pixel_y      <= sy[PIX_BITS-1:0];
      octant_index <= cmd.idx;
      last_of_step <= (cmd.idx == IDX_LAST);
      done_res     <= 1'b0;
    end else if (cmd.emit_done) begin
      pixel_x      <= '0;
      pixel_y      <= '0;
      octant_index <= '0;
      last_of_step <= 1'b1;
      done_res     <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasteriser: controller plus datapath.
//
// Input channel (in_valid/in_stall) carries opcode and four coordinates.
// A start beat (opcode 0) latches the centre and derives the radius as the
// floor square root of the squared centre-to-edge distance; it yields no
// output and keeps the block busy through the squaring of x and of y,
// the bit-per-cycle root recurrence and a commit.
// A step beat (opcode 1) yields the eight mirrored pixels of the current
// octant point, one per cycle while the receiver does not stall, the
// eighth flagged last_of_step; acceptance is registered in the state
// register before emission, each pixel is registered at the output, and
// no new beat is taken until the eighth pixel is emitted. A step once the
// circle is complete, or with no circle started, yields one beat with done_res set.
// Output channel (out_valid/out_stall) sits behind a single output
// register; a stall holds that beat and pauses emission, while the input
// side may still take the next beat once the block is between items.
// Synchronous reset (rst) clears the controller, empties the output and
// leaves no circle in progress.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [COORD_BITS-1:0]               center_x,
  input  logic [COORD_BITS-1:0]               center_y,
  input  logic [COORD_BITS-1:0]               edge_x,
  input  logic [COORD_BITS-1:0]               edge_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x,
  output logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y,
  output logic [mcr_pkg::IDX_BITS-1:0]        octant_index,
  output logic                                last_of_step,
  output logic                                done_res
);
  import mcr_pkg::*;

  cmd_t    cmd;
  status_t status;

  mcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mcr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .center_x     (center_x),
    .center_y     (center_y),
    .edge_x       (edge_x),
    .edge_y       (edge_y),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .octant_index (octant_index),
    .last_of_step (last_of_step),
    .done_res     (done_res)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the midpoint circle rasteriser: scoreboard class, drivers and checks.
module tb;

  localparam int COORD_BITS = 12;
  localparam int CMAX       = (1 << COORD_BITS) - 1;
  localparam int CYCLE_CAP  = 400000;
  localparam int DRAIN_WAIT = 30;

  typedef struct packed {
    logic signed [mcr_pkg::PIX_BITS-1:0] px;
    logic signed [mcr_pkg::PIX_BITS-1:0] py;
    logic [mcr_pkg::IDX_BITS-1:0]        idx;
    logic                                last;
    logic                                done;
  } pixel_beat_t;

  class circle_scoreboard;
    logic [COORD_BITS-1:0]        org_x, org_y;
    logic [COORD_BITS:0]          pos_x, pos_y;
    logic signed [COORD_BITS+4:0] dec;
    bit                           drawing;
    pixel_beat_t                  pending[$];
    int                           errors, pixels_seen, dones_seen, circles;

    function new();
      org_x = '0;
      org_y = '0;
      pos_x = '0;
      pos_y = '0;
      dec = '0;
      drawing = 1'b0;
      errors = 0;
      pixels_seen = 0;
      dones_seen = 0;
      circles = 0;
    endfunction

    function void push_pixel(int px, int py, int idx);
      pixel_beat_t b;
      b.px = px[mcr_pkg::PIX_BITS-1:0];
      b.py = py[mcr_pkg::PIX_BITS-1:0];
      b.idx = idx[mcr_pkg::IDX_BITS-1:0];
      b.last = (b.idx == mcr_pkg::IDX_LAST);
      b.done = 1'b0;
      pending.push_back(b);
    endfunction

    // Works out the beats one accepted input will produce and updates the circle state.
    function void note_input(logic op, logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
                             logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
      int dx, dy, x, y, p, ox, oy;
      longint unsigned sq, root, t;
      pixel_beat_t b;
      if (op == mcr_pkg::OP_START) begin
        dx = int'(ex) - int'(cx);
        dy = int'(ey) - int'(cy);
        sq = longint'(dx * dx + dy * dy);
        root = 0;
        for (int k = 24; k >= 0; k--) begin
          t = root | (64'd1 << k);
          if (t * t <= sq) root = t;
        end
        org_x = cx;
        org_y = cy;
        pos_x = '0;
        pos_y = root[COORD_BITS:0];
        dec = (COORD_BITS+5)'(3 - 2 * int'(pos_y));
        drawing = 1'b1;
        circles++;
      end else if (!drawing || pos_x > pos_y) begin
        drawing = 1'b0;
        b = '0;
        b.last = 1'b1;
        b.done = 1'b1;
        pending.push_back(b);
      end else begin
        ox = int'(org_x);
        oy = int'(org_y);
        x = int'(pos_x);
        y = int'(pos_y);
        p = dec;
        push_pixel(ox + x, oy + y, 0);
        push_pixel(ox + y, oy + x, 1);
        push_pixel(ox + y, oy - x, 2);
        push_pixel(ox + x, oy - y, 3);
        push_pixel(ox - x, oy - y, 4);
        push_pixel(ox - y, oy - x, 5);
        push_pixel(ox - y, oy + x, 6);
        push_pixel(ox - x, oy + y, 7);
        if (p >= 0) begin
          p += 4 * (x - y) + 10;
          if (y > 0) y--;
        end else begin
          p += 4 * x + 6;
        end
        x++;
        dec = p[COORD_BITS+4:0];
        pos_x = x[COORD_BITS:0];
        pos_y = y[COORD_BITS:0];
      end
    endfunction

    function void check_result(pixel_beat_t got);
      pixel_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat x=%0d y=%0d idx=%0d last=%0b done=%0b", $time,
                 got.px, got.py, got.idx, got.last, got.done);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.done) dones_seen++;
      else pixels_seen++;
      if (got !== want) begin
        $display("%0t: mismatch expected x=%0d y=%0d idx=%0d last=%0b done=%0b,",
                 $time, want.px, want.py, want.idx, want.last, want.done,
                 " got x=%0d y=%0d idx=%0d last=%0b done=%0b",
                 got.px, got.py, got.idx, got.last, got.done);
        errors++;
      end
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                opcode = mcr_pkg::OP_START;
  logic [COORD_BITS-1:0]               center_x = '0;
  logic [COORD_BITS-1:0]               center_y = '0;
  logic [COORD_BITS-1:0]               edge_x = '0;
  logic [COORD_BITS-1:0]               edge_y = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_x;
  logic signed [mcr_pkg::PIX_BITS-1:0] pixel_y;
  logic [mcr_pkg::IDX_BITS-1:0]        octant_index;
  logic                                last_of_step;
  logic                                done_res;

  circle_scoreboard sb;
  int gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int cycles = 0;

  midpoint_circle_rasterizer #(.COORD_BITS(COORD_BITS)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .center_x(center_x), .center_y(center_y),
    .edge_x(edge_x), .edge_y(edge_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .octant_index(octant_index),
    .last_of_step(last_of_step), .done_res(done_res)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall)
        sb.check_result({pixel_x, pixel_y, octant_index, last_of_step, done_res});
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Holds valid until the beat is taken; the next call either lowers it or loads the next beat.
  task automatic send_item(input logic op, input logic [COORD_BITS-1:0] cx,
                           input logic [COORD_BITS-1:0] cy, input logic [COORD_BITS-1:0] ex,
                           input logic [COORD_BITS-1:0] ey);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    center_x <= cx;
    center_y <= cy;
    edge_x <= ex;
    edge_y <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(op, cx, cy, ex, ey);
    items_sent++;
  endtask

  // Coordinates ride along on a step beat but are ignored, so they are random.
  task automatic step_item();
    send_item(mcr_pkg::OP_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
              COORD_BITS'($urandom), COORD_BITS'($urandom));
  endtask

  function automatic logic [COORD_BITS-1:0] near(logic [COORD_BITS-1:0] c, int span);
    int off, e;
    off = int'($urandom_range(2 * span)) - span;
    e = int'(c) + off;
    if (e < 0 || e > CMAX) e = int'(c) - off;
    return e[COORD_BITS-1:0];
  endfunction

  // Mostly whole small circles; some larger ones abandoned by a fresh start, plus noise.
  task automatic run_random(int quota);
    int stop, mode;
    logic [COORD_BITS-1:0] cx, cy;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      mode = $urandom_range(99);
      cx = COORD_BITS'($urandom);
      cy = COORD_BITS'($urandom);
      if (mode < 8) begin
        send_item(1'($urandom), cx, cy, COORD_BITS'($urandom), COORD_BITS'($urandom));
      end else if (mode < 72) begin
        send_item(mcr_pkg::OP_START, cx, cy, near(cx, 24), near(cy, 24));
        do step_item(); while (sb.drawing);
        if ($urandom_range(3) == 0) step_item();
      end else if (mode < 92) begin
        send_item(mcr_pkg::OP_START, cx, cy, near(cx, 400), near(cy, 400));
        repeat ($urandom_range(1, 10)) step_item();
      end else begin
        send_item(mcr_pkg::OP_START, cx, cy, COORD_BITS'($urandom), COORD_BITS'($urandom));
        repeat ($urandom_range(1, 5)) step_item();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // step with no circle, then a zero radius circle run past its end
    step_item();
    send_item(mcr_pkg::OP_START, '0, '0, '0, '0);
    repeat (3) step_item();
    // largest radii at both corners, each start abandoning the one before
    send_item(mcr_pkg::OP_START, COORD_BITS'(CMAX), COORD_BITS'(CMAX), '0, '0);
    repeat (3) step_item();
    send_item(mcr_pkg::OP_START, '0, '0, COORD_BITS'(CMAX), COORD_BITS'(CMAX));
    repeat (2) step_item();
    send_item(mcr_pkg::OP_START, 12'd2048, 12'd2048, 12'd2051, 12'd2052);
    do step_item(); while (sb.drawing);
    send_item(mcr_pkg::OP_START, 12'd100, 12'd200, 12'd100, 12'd201);
    do step_item(); while (sb.drawing);
    step_item();

    run_random(95);
    gap_pct = 86;
    run_random(95);
    gap_pct = 0;
    stall_pct = 86;
    run_random(95);
    gap_pct = 28;
    stall_pct = 28;
    run_random(95);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d input beats in four idle/stall phases: %0d circles started,",
             items_sent, sb.circles);
    $display("%0d pixel beats and %0d done beats checked, %0d errors.",
             sb.pixels_seen, sb.dones_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
